@@ sv/rafw_pkg.sv @@
// ----------------------------------------------------------------------------
// rafw_pkg: shared definitions for the range-add / range-sum Fenwick block
// Field widths, reset constants, mode codes and the multiplier request.
// ----------------------------------------------------------------------------
package rafw_pkg;

    localparam int SIZE_DEFAULT = 1024;

    // lengths and one-based indices on the ports
    localparam int LEN_W = 11;
    // walk indices: a node index plus its low bit can reach twice the length
    localparam int IDX_W = 12;
    localparam int AMT_W = 32;
    localparam int SUM_W = 64;

    // largest length the register can express
    localparam int LEN_MAX = 2047;

    localparam logic [LEN_W-1:0] LEN_RESET = 11'd1024;

    localparam logic MODE_ADD   = 1'b0;
    localparam logic MODE_QUERY = 1'b1;

    // request to the shared multiplier: a (64 bits) times b (IDX_W bits), low 64 bits
    typedef struct packed {
        logic             start;
        logic [SUM_W-1:0] a;
        logic [IDX_W-1:0] b;
    } mul_req_t;

endpackage

@@ sv/rafw_mul.sv @@
// ----------------------------------------------------------------------------
// rafw_mul: multi-cycle 64 x 12 multiplier, low 64 bits of the product
// Two 32 x 12 partial products, one after the other, then one 64-bit add.
// ----------------------------------------------------------------------------
module rafw_mul (
    input  logic                           clk,
    input  logic                           rst_n,
    input  rafw_pkg::mul_req_t             req,
    output logic                           done,
    output logic [rafw_pkg::SUM_W-1:0]     prod
);

    localparam int HW = rafw_pkg::SUM_W / 2;
    localparam int BW = rafw_pkg::IDX_W;
    localparam int PW = HW + BW;

    typedef enum logic [1:0] {
        M_IDLE,
        M_LO,
        M_HI,
        M_SUM
    } phase_t;

    phase_t                      phase_reg;
    logic [rafw_pkg::SUM_W-1:0]  a_reg;
    logic [BW-1:0]               b_reg;
    logic [PW-1:0]               part_reg;
    logic [PW-1:0]               lo_reg;
    logic [rafw_pkg::SUM_W-1:0]  prod_reg;
    logic                        done_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= M_IDLE;
            done_reg  <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            case (phase_reg)
                M_IDLE:
                begin
                    if (req.start)
                    begin
                        a_reg     <= req.a;
                        b_reg     <= req.b;
                        phase_reg <= M_LO;
                    end
                end
                M_LO:
                begin
                    part_reg  <= PW'(a_reg[HW-1:0]) * PW'(b_reg);
                    phase_reg <= M_HI;
                end
                M_HI:
                begin
                    lo_reg    <= part_reg;
                    part_reg  <= PW'(a_reg[rafw_pkg::SUM_W-1:HW]) * PW'(b_reg);
                    phase_reg <= M_SUM;
                end
                M_SUM:
                begin
                    // upper partial product only reaches the top half
                    prod_reg  <= rafw_pkg::SUM_W'(lo_reg) + {part_reg[HW-1:0], {HW{1'b0}}};
                    done_reg  <= 1'b1;
                    phase_reg <= M_IDLE;
                end
                default:
                begin
                    phase_reg <= M_IDLE;
                end
            endcase
        end
    end

    assign done = done_reg;
    assign prod = prod_reg;

endmodule

@@ sv/range_add_range_sum_fenwick.sv @@
// Operation: an add walks the tree nodes from each end of the range, and a query
// walks the nodes of two prefixes; from each end at most log2(length) + 1 nodes
// are walked, and one add visits each node with a read and a write.
// The block takes one item at a time: item_ready is high only while idle. Reset
// clears control state and starts a clearing pass over min(SIZE, 2047) nodes
// (1024 by default) before the first item.
// ----------------------------------------------------------------------------
// range_add_range_sum_fenwick: range add and range sum over two Fenwick trees
// Both trees share one node memory; a sequencer walks the nodes and reuses
// one multiplier for the weighted deltas and the prefix products.
// ----------------------------------------------------------------------------
module range_add_range_sum_fenwick #(
    parameter int SIZE = rafw_pkg::SIZE_DEFAULT
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                item_valid,
    output logic                                item_ready,
    input  logic                                mode,
    input  logic [rafw_pkg::LEN_W-1:0]          left,
    input  logic [rafw_pkg::LEN_W-1:0]          right,
    input  logic signed [rafw_pkg::AMT_W-1:0]   amount,
    output logic                                result_valid,
    input  logic                                result_ready,
    output logic signed [rafw_pkg::SUM_W-1:0]   range_sum,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [rafw_pkg::LEN_W-1:0]          cfg_data
);

    localparam int LEN_W = rafw_pkg::LEN_W;
    localparam int IDX_W = rafw_pkg::IDX_W;
    localparam int SUM_W = rafw_pkg::SUM_W;
    localparam int AMT_W = rafw_pkg::AMT_W;
    localparam int NW    = 2 * SUM_W;
    localparam int DEPTH = (SIZE < rafw_pkg::LEN_MAX) ? SIZE : rafw_pkg::LEN_MAX;
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam logic [LEN_W-1:0] N_CAP = LEN_W'(DEPTH);

    typedef enum logic [3:0] {
        S_CLR,
        S_IDLE,
        S_ASTART,
        S_AMUL,
        S_URD,
        S_UWR,
        S_QWALK,
        S_QSTART,
        S_QMUL,
        S_QOUT
    } state_t;

    function automatic logic [IDX_W-1:0] low_bit(input logic [IDX_W-1:0] v);
        return v & (~v + IDX_W'(1));
    endfunction

    function automatic logic [AW-1:0] node_addr(input logic [IDX_W-1:0] i);
        logic [IDX_W-1:0] t;
        t = i - IDX_W'(1);
        return t[AW-1:0];
    endfunction

    state_t                 state_reg;
    logic [AW-1:0]          clr_idx_reg;
    logic [LEN_W-1:0]       active_length_reg;
    logic [LEN_W-1:0]       n_reg;
    logic [LEN_W-1:0]       left_reg;
    logic [LEN_W-1:0]       right_reg;
    logic [SUM_W-1:0]       d_reg;
    logic                   at_r1_reg;
    logic [IDX_W-1:0]       idx_reg;
    logic [SUM_W-1:0]       dd_reg;
    logic [SUM_W-1:0]       dw_reg;
    logic [IDX_W-1:0]       pidx_reg;
    logic [IDX_W-1:0]       px_reg;
    logic [LEN_W-1:0]       lm1_reg;
    logic                   second_reg;
    logic                   rd_pend_reg;
    logic [SUM_W-1:0]       s_acc_reg;
    logic [SUM_W-1:0]       w_acc_reg;
    logic [SUM_W-1:0]       first_reg;
    logic [SUM_W-1:0]       sum_reg;
    logic                   result_valid_reg;
    logic [SUM_W-1:0]       range_sum_reg;

    // node memory: {weighted tree node, difference tree node}
    logic [NW-1:0]          mem [0:DEPTH-1];
    logic [NW-1:0]          rdata_reg;

    logic                   mem_we;
    logic [AW-1:0]          mem_waddr;
    logic [NW-1:0]          mem_wdata;
    logic                   mem_re;
    logic [AW-1:0]          mem_raddr;

    logic [LEN_W-1:0]       n_now;
    logic [LEN_W-1:0]       l_fix;
    logic [LEN_W-1:0]       r_clamp;
    logic [IDX_W-1:0]       r_plus1;
    logic                   upd_ok;

    rafw_pkg::mul_req_t     mul_req;
    logic                   mul_done;
    logic [SUM_W-1:0]       mul_p;

    assign n_now   = (active_length_reg > N_CAP) ? N_CAP : active_length_reg;
    assign l_fix   = (left == '0) ? LEN_W'(1) : left;
    assign r_clamp = (right > n_now) ? n_now : right;
    assign r_plus1 = IDX_W'(right_reg) + IDX_W'(1);
    assign upd_ok  = (idx_reg != '0) && (idx_reg <= IDX_W'(n_reg));

    always_comb
    begin
        mem_we    = 1'b0;
        mem_waddr = clr_idx_reg;
        mem_wdata = '0;
        mem_re    = 1'b0;
        mem_raddr = node_addr(idx_reg);
        case (state_reg)
            S_CLR:
            begin
                mem_we = 1'b1;
            end
            S_URD:
            begin
                mem_re = upd_ok;
            end
            S_UWR:
            begin
                mem_we    = 1'b1;
                mem_waddr = node_addr(idx_reg);
                mem_wdata = {rdata_reg[NW-1:SUM_W] + dw_reg, rdata_reg[SUM_W-1:0] + dd_reg};
            end
            S_QWALK:
            begin
                mem_re    = (pidx_reg != '0);
                mem_raddr = node_addr(pidx_reg);
            end
            default:
            begin
                mem_we = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_waddr] <= mem_wdata;
        end
        if (mem_re)
        begin
            rdata_reg <= mem[mem_raddr];
        end
    end

    always_comb
    begin
        mul_req.start = (state_reg == S_ASTART) || (state_reg == S_QSTART);
        mul_req.a     = (state_reg == S_QSTART) ? s_acc_reg : d_reg;
        if (state_reg == S_QSTART)
        begin
            mul_req.b = px_reg;
        end
        else if (at_r1_reg)
        begin
            mul_req.b = r_plus1;
        end
        else
        begin
            mul_req.b = IDX_W'(left_reg);
        end
    end

    rafw_mul u_mul (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (mul_req),
        .done  (mul_done),
        .prod  (mul_p)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg         <= S_CLR;
            clr_idx_reg       <= '0;
            active_length_reg <= rafw_pkg::LEN_RESET;
            at_r1_reg         <= 1'b0;
            second_reg        <= 1'b0;
            rd_pend_reg       <= 1'b0;
            result_valid_reg  <= 1'b0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                active_length_reg <= cfg_data;
            end
            // the output step reloads the register on its own
            if (result_valid_reg && result_ready && state_reg != S_QOUT)
            begin
                result_valid_reg <= 1'b0;
            end

            case (state_reg)
                S_CLR:
                begin
                    clr_idx_reg <= clr_idx_reg + AW'(1);
                    if (clr_idx_reg == AW'(DEPTH - 1))
                    begin
                        state_reg <= S_IDLE;
                    end
                end
                S_IDLE:
                begin
                    if (item_valid)
                    begin
                        n_reg     <= n_now;
                        left_reg  <= left;
                        right_reg <= right;
                        d_reg     <= {{(SUM_W - AMT_W){amount[AMT_W-1]}}, amount};
                        if (mode == rafw_pkg::MODE_ADD)
                        begin
                            at_r1_reg <= 1'b0;
                            state_reg <= S_ASTART;
                        end
                        else if (l_fix > r_clamp)
                        begin
                            sum_reg   <= '0;
                            state_reg <= S_QOUT;
                        end
                        else
                        begin
                            pidx_reg    <= IDX_W'(r_clamp);
                            px_reg      <= IDX_W'(r_clamp) + IDX_W'(1);
                            lm1_reg     <= l_fix - LEN_W'(1);
                            second_reg  <= 1'b0;
                            rd_pend_reg <= 1'b0;
                            s_acc_reg   <= '0;
                            w_acc_reg   <= '0;
                            state_reg   <= S_QWALK;
                        end
                    end
                end
                S_ASTART:
                begin
                    state_reg <= S_AMUL;
                end
                S_AMUL:
                begin
                    if (mul_done)
                    begin
                        // right end takes the negated deltas at right + 1
                        if (at_r1_reg)
                        begin
                            dd_reg  <= '0 - d_reg;
                            dw_reg  <= '0 - mul_p;
                            idx_reg <= r_plus1;
                        end
                        else
                        begin
                            dd_reg  <= d_reg;
                            dw_reg  <= mul_p;
                            idx_reg <= IDX_W'(left_reg);
                        end
                        state_reg <= S_URD;
                    end
                end
                S_URD:
                begin
                    if (upd_ok)
                    begin
                        state_reg <= S_UWR;
                    end
                    else if (!at_r1_reg)
                    begin
                        at_r1_reg <= 1'b1;
                        state_reg <= S_ASTART;
                    end
                    else
                    begin
                        state_reg <= S_IDLE;
                    end
                end
                S_UWR:
                begin
                    idx_reg   <= idx_reg + low_bit(idx_reg);
                    state_reg <= S_URD;
                end
                S_QWALK:
                begin
                    if (rd_pend_reg)
                    begin
                        s_acc_reg <= s_acc_reg + rdata_reg[SUM_W-1:0];
                        w_acc_reg <= w_acc_reg + rdata_reg[NW-1:SUM_W];
                    end
                    if (pidx_reg != '0)
                    begin
                        pidx_reg    <= pidx_reg - low_bit(pidx_reg);
                        rd_pend_reg <= 1'b1;
                    end
                    else
                    begin
                        rd_pend_reg <= 1'b0;
                        // advance once the last read has been summed
                        if (!rd_pend_reg)
                        begin
                            state_reg <= S_QSTART;
                        end
                    end
                end
                S_QSTART:
                begin
                    state_reg <= S_QMUL;
                end
                S_QMUL:
                begin
                    if (mul_done)
                    begin
                        if (!second_reg)
                        begin
                            first_reg  <= mul_p - w_acc_reg;
                            second_reg <= 1'b1;
                            pidx_reg   <= IDX_W'(lm1_reg);
                            px_reg     <= IDX_W'(lm1_reg) + IDX_W'(1);
                            s_acc_reg  <= '0;
                            w_acc_reg  <= '0;
                            state_reg  <= S_QWALK;
                        end
                        else
                        begin
                            sum_reg   <= first_reg - (mul_p - w_acc_reg);
                            state_reg <= S_QOUT;
                        end
                    end
                end
                S_QOUT:
                begin
                    // hold until the output register is free
                    if (!result_valid_reg || result_ready)
                    begin
                        result_valid_reg <= 1'b1;
                        range_sum_reg    <= sum_reg;
                        state_reg        <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign item_ready   = (state_reg == S_IDLE);
    assign cfg_ready    = 1'b1;
    assign result_valid = result_valid_reg;
    assign range_sum    = range_sum_reg;

`ifndef SYNTHESIS
    a_upd_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_UWR) |-> (idx_reg != '0 && idx_reg <= IDX_W'(n_reg)))
        else $error("node update outside the active length");

    a_mul_expected: assert property (@(posedge clk) disable iff (!rst_n)
        mul_done |-> (state_reg == S_AMUL || state_reg == S_QMUL))
        else $error("multiplier finished while nobody waits for it");

    a_pend_in_walk: assert property (@(posedge clk) disable iff (!rst_n)
        rd_pend_reg |-> (state_reg == S_QWALK))
        else $error("prefix read left pending outside the walk");

    a_result_from_query: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(result_valid_reg) |-> ($past(state_reg) == S_QOUT))
        else $error("result raised outside the query output step");
`endif

endmodule

@@ test/tb_range_add_range_sum_fenwick.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_range_add_range_sum_fenwick: self-checking bench for the Fenwick block
// Drives range adds and range-sum queries over several active lengths. A
// scoreboard keeps its own pair of difference trees, works out every range sum
// and compares it with the block's output, with random idling on both sides.
// ----------------------------------------------------------------------------
module tb_range_add_range_sum_fenwick;

    localparam int LEN_W       = rafw_pkg::LEN_W;
    localparam int AMT_W       = rafw_pkg::AMT_W;
    localparam int SUM_W       = rafw_pkg::SUM_W;
    localparam int TREE_DEPTH  = rafw_pkg::SIZE_DEFAULT;
    localparam int SETTLE      = 100;
    localparam int LONG_HOLD   = 300;
    localparam int CYCLE_LIMIT = 1000000;
    localparam int PHASE_ITEMS = 200;

    class fenwick_scoreboard;
        logic [SUM_W-1:0] diff_tree     [1:TREE_DEPTH];
        logic [SUM_W-1:0] weighted_tree [1:TREE_DEPTH];
        logic [SUM_W-1:0] sum_queue [$];
        int unsigned      active_len;
        int               errors;
        int               sums_checked;
        int               items_seen;

        function new();
            foreach (diff_tree[i])
            begin
                diff_tree[i]     = '0;
                weighted_tree[i] = '0;
            end
            active_len = rafw_pkg::LEN_RESET;
        endfunction

        function void set_length(logic [LEN_W-1:0] len);
            active_len = len;
        endfunction

        function int unsigned span();
            return (active_len > TREE_DEPTH) ? TREE_DEPTH : active_len;
        endfunction

        function void tree_add(bit weighted, int unsigned idx, logic [SUM_W-1:0] delta);
            int unsigned n;
            int unsigned i;
            n = span();
            i = idx;
            if (i == 0 || i > n)
                return;
            while (i <= n)
            begin
                if (weighted)
                    weighted_tree[i] += delta;
                else
                    diff_tree[i] += delta;
                i += i & (~i + 1);
            end
        endfunction

        function logic [SUM_W-1:0] tree_prefix(bit weighted, int unsigned idx);
            logic [SUM_W-1:0] s;
            int unsigned      i;
            s = '0;
            i = idx;
            while (i != 0 && i <= TREE_DEPTH)
            begin
                s += weighted ? weighted_tree[i] : diff_tree[i];
                i -= i & (~i + 1);
            end
            return s;
        endfunction

        // a[1] + .. + a[x] = S(x)*(x+1) - T(x)
        function logic [SUM_W-1:0] array_prefix_sum(int unsigned x);
            logic [SUM_W-1:0] s;
            logic [SUM_W-1:0] w;
            s = tree_prefix(1'b0, x);
            w = tree_prefix(1'b1, x);
            return s * (64'(x) + 64'd1) - w;
        endfunction

        function void note_item(logic m, logic [LEN_W-1:0] l, logic [LEN_W-1:0] r,
                                logic [AMT_W-1:0] a);
            logic [SUM_W-1:0] d;
            int unsigned      lo;
            int unsigned      hi;
            int unsigned      n;
            d  = {{(SUM_W-AMT_W){a[AMT_W-1]}}, a};
            n  = span();
            lo = l;
            items_seen++;
            if (m == rafw_pkg::MODE_ADD)
            begin
                hi = r + 1;
                tree_add(1'b0, lo, d);
                tree_add(1'b1, lo, 64'(lo) * d);
                tree_add(1'b0, hi, 64'd0 - d);
                tree_add(1'b1, hi, 64'd0 - 64'(hi) * d);
            end
            else
            begin
                hi = r;
                if (lo == 0)
                    lo = 1;
                if (hi > n)
                    hi = n;
                if (lo > hi)
                    sum_queue.push_back('0);
                else
                    sum_queue.push_back(array_prefix_sum(hi) - array_prefix_sum(lo - 1));
            end
        endfunction

        function void check_sum(logic [SUM_W-1:0] got);
            logic [SUM_W-1:0] want;
            if (sum_queue.size() == 0)
            begin
                $error("range_sum: unexpected result, actual %0d", $signed(got));
                errors++;
                return;
            end
            want = sum_queue.pop_front();
            sums_checked++;
            if (got !== want)
            begin
                $error("range_sum mismatch: expected %0d, actual %0d",
                       $signed(want), $signed(got));
                errors++;
            end
        endfunction
    endclass

    logic                    clk;
    logic                    rst_n;
    logic                    item_valid;
    logic                    item_ready;
    logic                    mode;
    logic [LEN_W-1:0]        left;
    logic [LEN_W-1:0]        right;
    logic signed [AMT_W-1:0] amount;
    logic                    result_valid;
    logic                    result_ready;
    logic signed [SUM_W-1:0] range_sum;
    logic                    cfg_valid;
    logic                    cfg_ready;
    logic [LEN_W-1:0]        cfg_data;

    fenwick_scoreboard sb;
    int                cycle_count;
    int                send_idle_pct;
    int                recv_idle_pct;
    int                hold_requests;
    int                hold_served;
    int                stall_left;
    int                lengths_used;

    range_add_range_sum_fenwick u_top (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_ready   (item_ready),
        .mode         (mode),
        .left         (left),
        .right        (right),
        .amount       (amount),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .range_sum    (range_sum),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_data     (cfg_data)
    );

    always #5 clk = ~clk;

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("Some tests failed");
            $finish;
        end
    end

    // receiver: random short stalls, plus one long hold on request
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (hold_served != hold_requests)
            begin
                hold_served = hold_requests;
                stall_left  = LONG_HOLD;
            end
            else if (stall_left == 0 && recv_idle_pct != 0 &&
                     $urandom_range(0, 99) < recv_idle_pct)
                stall_left = $urandom_range(1, 4);
            if (stall_left != 0)
            begin
                result_ready <= 1'b0;
                stall_left--;
            end
            else
                result_ready <= 1'b1;
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && result_valid && result_ready)
            sb.check_sum(range_sum);
    end

    task automatic send_item(input logic m, input logic [LEN_W-1:0] l,
                             input logic [LEN_W-1:0] r, input logic [AMT_W-1:0] a);
        int gap;
        gap = 0;
        if (send_idle_pct != 0 && $urandom_range(0, 99) < send_idle_pct)
            gap = $urandom_range(1, 4);
        if (gap != 0)
        begin
            item_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        item_valid <= 1'b1;
        mode       <= m;
        left       <= l;
        right      <= r;
        amount     <= a;
        @(posedge clk);
        while (!item_ready)
            @(posedge clk);
        sb.note_item(m, l, r, a);
    endtask

    // drop valid and wait for the block to go quiet
    task automatic drain();
        item_valid <= 1'b0;
        while (sb.sum_queue.size() != 0)
            @(posedge clk);
        repeat (SETTLE) @(posedge clk);
    endtask

    task automatic write_length(input logic [LEN_W-1:0] len);
        drain();
        cfg_valid <= 1'b1;
        cfg_data  <= len;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        cfg_valid <= 1'b0;
        sb.set_length(len);
        lengths_used++;
    endtask

    task automatic random_item();
        logic             m;
        logic [LEN_W-1:0] l;
        logic [LEN_W-1:0] r;
        logic [LEN_W-1:0] t;
        logic [AMT_W-1:0] a;
        int unsigned      n;
        n = sb.span();
        m = 1'($urandom_range(0, 1));
        if (n > 0 && $urandom_range(0, 9) < 8)
        begin
            l = LEN_W'($urandom_range(1, n));
            r = LEN_W'($urandom_range(1, n));
            if (l > r)
            begin
                t = l;
                l = r;
                r = t;
            end
            // single-entry load now and then
            if (m == rafw_pkg::MODE_ADD && $urandom_range(0, 3) == 0)
                r = l;
        end
        else
        begin
            l = LEN_W'($urandom);
            r = LEN_W'($urandom);
        end
        case ($urandom_range(0, 3))
            0:       a = 32'($urandom_range(0, 200)) - 32'd100;
            1:       a = $urandom;
            2:       a = $urandom_range(0, 1) ? 32'h7FFF_FFFF : 32'h8000_0000;
            default: a = $urandom_range(0, 65535);
        endcase
        send_item(m, l, r, a);
    endtask

    logic [LEN_W-1:0] phase_len [8];

    initial
    begin
        sb            = new();
        clk           = 1'b0;
        rst_n         = 1'b0;
        item_valid    = 1'b0;
        mode          = rafw_pkg::MODE_ADD;
        left          = '0;
        right         = '0;
        amount        = '0;
        result_ready  = 1'b0;
        cfg_valid     = 1'b0;
        cfg_data      = '0;
        cycle_count   = 0;
        send_idle_pct = 0;
        recv_idle_pct = 0;
        hold_requests = 0;
        hold_served   = 0;
        stall_left    = 0;
        lengths_used  = 0;

        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        write_length(rafw_pkg::LEN_RESET);

        // directed: loads, extremes and odd ranges
        send_item(rafw_pkg::MODE_ADD,   11'd1,    11'd1,    32'd5);
        send_item(rafw_pkg::MODE_ADD,   11'd1024, 11'd1024, 32'hFFFF_FFFF);
        send_item(rafw_pkg::MODE_ADD,   11'd1,    11'd1024, 32'h7FFF_FFFF);
        send_item(rafw_pkg::MODE_ADD,   11'd512,  11'd700,  32'h8000_0000);
        send_item(rafw_pkg::MODE_ADD,   11'd0,    11'd3,    32'd7);
        send_item(rafw_pkg::MODE_ADD,   11'd10,   11'd5,    32'd3);
        send_item(rafw_pkg::MODE_ADD,   11'd1030, 11'd2047, 32'd9);
        send_item(rafw_pkg::MODE_ADD,   11'd2047, 11'd0,    32'hFFFF_FFFB);
        send_item(rafw_pkg::MODE_ADD,   11'd1023, 11'd1023, 32'h8000_0000);
        send_item(rafw_pkg::MODE_QUERY, 11'd1,    11'd1024, 32'd0);
        send_item(rafw_pkg::MODE_QUERY, 11'd1,    11'd1,    32'd0);
        send_item(rafw_pkg::MODE_QUERY, 11'd1024, 11'd1024, 32'hFFFF_FFFF);
        send_item(rafw_pkg::MODE_QUERY, 11'd0,    11'd5,    32'd0);
        send_item(rafw_pkg::MODE_QUERY, 11'd5,    11'd2047, 32'd0);
        send_item(rafw_pkg::MODE_QUERY, 11'd700,  11'd600,  32'd0);
        send_item(rafw_pkg::MODE_QUERY, 11'd2047, 11'd2047, 32'd0);
        send_item(rafw_pkg::MODE_QUERY, 11'd0,    11'd0,    32'd0);
        send_item(rafw_pkg::MODE_QUERY, 11'd512,  11'd700,  32'd0);
        send_item(rafw_pkg::MODE_QUERY, 11'd1000, 11'd1023, 32'd0);
        send_item(rafw_pkg::MODE_QUERY, 11'd6,    11'd10,   32'd0);

        phase_len = '{11'd1024, 11'd1, 11'd0, 11'd2047, 11'd13, 11'd300,
                      11'($urandom_range(1, 1024)), 11'd1024};

        for (int p = 0; p < 8; p++)
        begin
            write_length(phase_len[p]);
            if (p == 7)
            begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
            else
            begin
                send_idle_pct = (p % 3 == 2) ? 0 : 25;
                recv_idle_pct = (p % 3 == 1) ? 0 : 25;
            end
            // stall the output long enough to back up the input
            if (p == 3)
                hold_requests++;
            for (int k = 0; k < PHASE_ITEMS; k++)
                random_item();
        end

        drain();

        $display("Ran %0d items over %0d length settings; %0d range sums checked.",
                 sb.items_seen, lengths_used, sb.sums_checked);
        if (sb.errors == 0 && sb.sum_queue.size() == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule

@@ range_add_range_sum_fenwick.f @@
sv/rafw_pkg.sv
sv/rafw_mul.sv
sv/range_add_range_sum_fenwick.sv
test/tb_range_add_range_sum_fenwick.sv
